// ===== hdl/arm_psr_transfer_unit_top_assert.svh =====
// Assertion macros for the status register transfer unit top level.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef ARM_PSR_TRANSFER_UNIT_TOP_ASSERT_SVH
`define ARM_PSR_TRANSFER_UNIT_TOP_ASSERT_SVH

// Condition holding in the same cycle as the trigger.
`define APSRTU_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// Delayed form: condition holding after the trigger rather than with it.
`define APSRTU_ASSERT_LAT2(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> ##2 (cond)) else $error(msg);

`endif

// ===== hdl/apsrtu_pkg.sv =====
// Shared types, codes and mask tables for the status register transfer unit.
// No dependencies.
package apsrtu_pkg;

    localparam logic [2:0] ARCH_RESET     = 3'd4;
    localparam logic [4:0] USER_MODE_BITS = 5'h10;
    localparam logic       MODE_MRS       = 1'b0;
    localparam logic       MODE_MSR       = 1'b1;

    typedef enum logic [2:0] {
        FAULT_OK      = 3'd0,
        FAULT_ENC     = 3'd1,
        FAULT_UNALLOC = 3'd2,
        FAULT_NO_SPSR = 3'd3,
        FAULT_STATE   = 3'd4
    } t_fault;

    typedef struct packed {
        logic        mode;
        logic [31:0] instruction;
        logic [31:0] source_value;
        logic [31:0] current_status;
        logic [31:0] saved_status;
        logic        saved_present;
        logic        cond_pass;
    } t_item;

    typedef struct packed {
        logic [3:0]  dest_reg;
        logic        reg_write;
        logic [31:0] reg_result;
        logic        cpsr_write;
        logic [31:0] new_cpsr;
        logic        spsr_write;
        logic [31:0] new_spsr;
        t_fault      fault;
    } t_result;

    // Levels above four fall into the default arm and act as four.
    function automatic logic [31:0] lvl_priv_bits(input logic [2:0] lvl);
        case (lvl)
            3'd0, 3'd1, 3'd2, 3'd3: lvl_priv_bits = 32'h0000000f;
            default:                lvl_priv_bits = 32'h000001df;
        endcase
    endfunction

    function automatic logic [31:0] lvl_state_bits(input logic [2:0] lvl);
        case (lvl)
            3'd0:       lvl_state_bits = 32'h00000000;
            3'd1, 3'd2: lvl_state_bits = 32'h00000020;
            default:    lvl_state_bits = 32'h01000020;
        endcase
    endfunction

    function automatic logic [31:0] lvl_unalloc_bits(input logic [2:0] lvl);
        case (lvl)
            3'd0:    lvl_unalloc_bits = 32'h0fffff20;
            3'd1:    lvl_unalloc_bits = 32'h0fffff00;
            3'd2:    lvl_unalloc_bits = 32'h07ffff00;
            3'd3:    lvl_unalloc_bits = 32'h06ffff00;
            default: lvl_unalloc_bits = 32'h06f0fc00;
        endcase
    endfunction

    function automatic logic [31:0] lvl_user_bits(input logic [2:0] lvl);
        case (lvl)
            3'd0, 3'd1: lvl_user_bits = 32'hf0000000;
            3'd2, 3'd3: lvl_user_bits = 32'hf8000000;
            default:    lvl_user_bits = 32'hf80f0200;
        endcase
    endfunction

endpackage

// ===== hdl/apsrtu_exec.sv =====
// Combinational MRS / MSR execution between the input and result registers.
// Depends on apsrtu_pkg.
module apsrtu_exec import apsrtu_pkg::*; (
    input  t_item      i_item,
    input  logic [2:0] i_arch_level,
    output t_result    o_result
);

    logic [31:0] insn;
    logic        rbit;
    logic [63:0] imm_pair;
    logic [4:0]  rot;
    logic [31:0] operand;
    logic [31:0] bmask;
    logic [31:0] m_user;
    logic [31:0] m_priv;
    logic [31:0] m_state;
    logic [31:0] m_spsr;
    logic [31:0] m_cpsr;
    logic        privileged;
    logic        enc_bad;

    assign insn       = i_item.instruction;
    assign rbit       = insn[22];
    assign rot        = {insn[11:8], 1'b0};
    assign imm_pair   = {24'd0, insn[7:0], 24'd0, insn[7:0]} >> rot;
    assign operand    = insn[25] ? imm_pair[31:0] : i_item.source_value;
    assign bmask      = {{8{insn[19]}}, {8{insn[18]}}, {8{insn[17]}}, {8{insn[16]}}};
    assign m_user     = lvl_user_bits(i_arch_level);
    assign m_priv     = lvl_priv_bits(i_arch_level);
    assign m_state    = lvl_state_bits(i_arch_level);
    assign m_spsr     = bmask & (m_user | m_priv | m_state);
    assign privileged = i_item.current_status[4:0] != USER_MODE_BITS;
    assign m_cpsr     = privileged ? (bmask & (m_user | m_priv)) : (bmask & m_user);
    // register form of MSR requires bits 7:4 clear
    assign enc_bad    = !insn[25] && (insn[7:4] != 4'd0);

    always_comb begin
        o_result = '0;
        o_result.fault = FAULT_OK;
        if (i_item.mode == MODE_MRS) begin
            o_result.dest_reg = insn[15:12];
            if (insn[19:16] != 4'hf || insn[11:0] != 12'd0) begin
                o_result.fault = FAULT_ENC;
            end else begin
                o_result.reg_result = !rbit ? i_item.current_status :
                                      (i_item.saved_present ? i_item.saved_status : 32'd0);
                o_result.reg_write  = i_item.cond_pass;
            end
        end else if (enc_bad) begin
            o_result.fault = FAULT_ENC;
        end else if ((operand & lvl_unalloc_bits(i_arch_level)) != 32'd0) begin
            o_result.fault = FAULT_UNALLOC;
        end else if (rbit) begin
            if (!i_item.saved_present) begin
                o_result.fault = FAULT_NO_SPSR;
            end else begin
                o_result.new_spsr   = (i_item.saved_status & ~m_spsr) | (operand & m_spsr);
                o_result.spsr_write = i_item.cond_pass;
            end
        end else if (privileged && ((operand & m_state) != 32'd0)) begin
            o_result.fault = FAULT_STATE;
        end else begin
            o_result.new_cpsr   = (i_item.current_status & ~m_cpsr) | (operand & m_cpsr);
            o_result.cpsr_write = i_item.cond_pass;
        end
    end

endmodule

// ===== hdl/arm_psr_transfer_unit_top.sv =====
// Top level of the ARM status register transfer unit (MRS / MSR).
// Depends on apsrtu_pkg, apsrtu_exec and arm_psr_transfer_unit_top_assert.svh.

// The unit takes one instruction item per clock: busy never rises, so an item
// is accepted at every edge where start is high. Each item yields exactly one
// result, loaded into the result register at the edge after the item was
// accepted and shown on the o_ ports with o_strobe high for the one cycle that
// follows. On its way the item passes the input register, then the result
// register, with the MRS / MSR logic between them. The receiver
// cannot stall, so results must be taken in the cycle they appear. Write flags
// are only high together with o_strobe and only when the condition passed and
// no fault was found; faults are reported whatever the condition. The
// arch_level register (reset value four) picks the mask tables, and levels
// above four act as four. Change it only when no item is in flight.
`include "arm_psr_transfer_unit_top_assert.svh"

module arm_psr_transfer_unit_top import apsrtu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_mode,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_source_value,
    input  logic [31:0] i_current_status,
    input  logic [31:0] i_saved_status,
    input  logic        i_saved_present,
    input  logic        i_cond_pass,
    output logic        o_strobe,
    output logic [3:0]  o_dest_reg,
    output logic        o_reg_write,
    output logic [31:0] o_reg_result,
    output logic        o_cpsr_write,
    output logic [31:0] o_new_cpsr,
    output logic        o_spsr_write,
    output logic [31:0] o_new_spsr,
    output logic [2:0]  o_fault
);

    logic       r_arch_level;
    logic [2:0] r_arch;
    logic       r_in_valid;
    t_item      r_item;
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;
    logic       accept;

    // Pipeline never backs up: the receiver takes every result.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch <= ARCH_RESET;
        end else if (i_cfg_we) begin
            r_arch <= i_cfg_wdata;
        end
    end

    // Mark whether the configuration register has ever been written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch_level <= 1'b0;
        end else if (i_cfg_we) begin
            r_arch_level <= 1'b1;
        end
    end

    // Input stage: capture the item, hold payload when nothing arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.mode           <= i_mode;
            r_item.instruction    <= i_instruction;
            r_item.source_value   <= i_source_value;
            r_item.current_status <= i_current_status;
            r_item.saved_status   <= i_saved_status;
            r_item.saved_present  <= i_saved_present;
            r_item.cond_pass      <= i_cond_pass;
        end
    end

    apsrtu_exec u_exec (
        .i_item       (r_item),
        .i_arch_level (r_arch),
        .o_result     (n_res)
    );

    // Result stage: advance one item per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_res <= n_res;
        end
    end

    // Gate the write flags with the strobe so stale results never write.
    assign o_strobe     = r_out_valid;
    assign o_dest_reg   = r_res.dest_reg;
    assign o_reg_write  = r_out_valid && r_res.reg_write;
    assign o_reg_result = r_res.reg_result;
    assign o_cpsr_write = r_out_valid && r_res.cpsr_write;
    assign o_new_cpsr   = r_res.new_cpsr;
    assign o_spsr_write = r_out_valid && r_res.spsr_write;
    assign o_new_spsr   = r_res.new_spsr;
    assign o_fault      = r_res.fault;

    `APSRTU_ASSERT_LAT2(a_result_latency, accept, o_strobe, "result missing after accept")
    `APSRTU_ASSERT_NOW(a_fault_no_write, o_strobe && (o_fault != FAULT_OK),
        !(o_reg_write || o_cpsr_write || o_spsr_write), "write asserted on fault")
    `APSRTU_ASSERT_NOW(a_single_write, o_strobe,
        $onehot0({o_reg_write, o_cpsr_write, o_spsr_write}), "more than one write target")
    `APSRTU_ASSERT_NOW(a_arch_reset, !r_arch_level, r_arch == ARCH_RESET,
        "arch level moved without a write")

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for arm_psr_transfer_unit_top (MRS / MSR status transfers).
// Depends on apsrtu_pkg for the item, result and fault types and on the top level RTL.
// Directed and random items, random idle gaps, every arch level, scoreboard check.
module tb;
    import apsrtu_pkg::*;

    // Mask tables per architecture level; index 4 is the reset level.
    localparam logic [4:0][31:0] PRIV_BY_LEVEL = {32'h000001df, 32'h0000000f, 32'h0000000f,
                                                  32'h0000000f, 32'h0000000f};
    localparam logic [4:0][31:0] STATE_BY_LEVEL = {32'h01000020, 32'h01000020, 32'h00000020,
                                                   32'h00000020, 32'h00000000};
    localparam logic [4:0][31:0] UNALLOC_BY_LEVEL = {32'h06f0fc00, 32'h06ffff00, 32'h07ffff00,
                                                     32'h0fffff00, 32'h0fffff20};
    localparam logic [4:0][31:0] USER_BY_LEVEL = {32'hf80f0200, 32'hf8000000, 32'hf8000000,
                                                  32'hf0000000, 32'hf0000000};

    localparam int RESET_CYCLES = 7;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 120;

    // One backlog entry: either an item to issue or an arch_level write.
    typedef struct {
        bit          is_cfg;
        logic [2:0]  level;
        t_item       it;
    } t_backlog_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_wdata = 3'd0;
    logic        i_mode = 1'b0;
    logic [31:0] i_instruction = 32'h0;
    logic [31:0] i_source_value = 32'h0;
    logic [31:0] i_current_status = 32'h0;
    logic [31:0] i_saved_status = 32'h0;
    logic        i_saved_present = 1'b0;
    logic        i_cond_pass = 1'b0;
    logic        o_strobe;
    logic [3:0]  o_dest_reg;
    logic        o_reg_write;
    logic [31:0] o_reg_result;
    logic        o_cpsr_write;
    logic [31:0] o_new_cpsr;
    logic        o_spsr_write;
    logic [31:0] o_new_spsr;
    logic [2:0]  o_fault;

    t_backlog_entry instr_backlog[$];
    t_result        psr_expected[$];
    t_item          on_port;
    logic [2:0]     arch_shadow = ARCH_RESET;
    int             n_sent = 0;
    int             n_results = 0;
    int             mismatches = 0;
    int             gap_left = 0;
    int             calm_left = 0;
    int             idle_cycles = 0;

    arm_psr_transfer_unit_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_mode           (i_mode),
        .i_instruction    (i_instruction),
        .i_source_value   (i_source_value),
        .i_current_status (i_current_status),
        .i_saved_status   (i_saved_status),
        .i_saved_present  (i_saved_present),
        .i_cond_pass      (i_cond_pass),
        .o_strobe         (o_strobe),
        .o_dest_reg       (o_dest_reg),
        .o_reg_write      (o_reg_write),
        .o_reg_result     (o_reg_result),
        .o_cpsr_write     (o_cpsr_write),
        .o_new_cpsr       (o_new_cpsr),
        .o_spsr_write     (o_spsr_write),
        .o_new_spsr       (o_new_spsr),
        .o_fault          (o_fault)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Compute the status transfer an instruction causes at a given arch level.
    function automatic t_result transfer_outcome(input t_item it, input logic [2:0] level);
        t_result     r;
        logic [2:0]  lvl;
        logic [31:0] operand, bytes_on, allowed, user_m, priv_m, state_m;
        logic [63:0] twice;
        logic [4:0]  amt;
        logic        spsr_sel, privileged;
        int          k;
        r = '0;
        lvl = (level > 3'd4) ? 3'd4 : level;   // levels above four act as four
        user_m  = USER_BY_LEVEL[lvl];
        priv_m  = PRIV_BY_LEVEL[lvl];
        state_m = STATE_BY_LEVEL[lvl];
        spsr_sel = it.instruction[22];
        if (it.mode == MODE_MRS) begin
            r.dest_reg = it.instruction[15:12];
            if (it.instruction[19:16] != 4'hf || it.instruction[11:0] != 12'h000) begin
                r.fault = FAULT_ENC;
            end else begin
                // an absent SPSR reads as zero
                r.reg_result = spsr_sel ? (it.saved_present ? it.saved_status : 32'h0)
                                        : it.current_status;
                r.reg_write = it.cond_pass;
            end
        end else begin
            if (it.instruction[25]) begin
                amt = {it.instruction[11:8], 1'b0};
                twice = {24'h0, it.instruction[7:0], 24'h0, it.instruction[7:0]} >> amt;
                operand = twice[31:0];
            end else begin
                operand = it.source_value;
                if (it.instruction[7:4] != 4'h0)
                    r.fault = FAULT_ENC;
            end
            for (k = 0; k < 4; k++)
                bytes_on[8*k +: 8] = {8{it.instruction[16+k]}};
            if (r.fault == FAULT_OK && (operand & UNALLOC_BY_LEVEL[lvl]) != 32'h0)
                r.fault = FAULT_UNALLOC;
            if (r.fault == FAULT_OK) begin
                if (spsr_sel) begin
                    if (!it.saved_present) begin
                        r.fault = FAULT_NO_SPSR;
                    end else begin
                        allowed = bytes_on & (user_m | priv_m | state_m);
                        r.new_spsr = (it.saved_status & ~allowed) | (operand & allowed);
                        r.spsr_write = it.cond_pass;
                    end
                end else begin
                    privileged = it.current_status[4:0] != USER_MODE_BITS;
                    if (privileged && (operand & state_m) != 32'h0) begin
                        r.fault = FAULT_STATE;
                    end else begin
                        allowed = privileged ? (bytes_on & (user_m | priv_m))
                                             : (bytes_on & user_m);
                        r.new_cpsr = (it.current_status & ~allowed) | (operand & allowed);
                        r.cpsr_write = it.cond_pass;
                    end
                end
            end
        end
        return r;
    endfunction

    // Draw a random instruction item; most are well formed for the given level.
    function automatic t_item random_transfer(input logic [2:0] level);
        t_item       it;
        logic [2:0]  lvl;
        logic [31:0] legal;
        logic [63:0] twice;
        int unsigned pick;
        lvl = (level > 3'd4) ? 3'd4 : level;
        it.mode           = 1'($urandom_range(0, 1));
        it.instruction    = $urandom;
        it.source_value   = $urandom;
        it.current_status = $urandom;
        it.saved_status   = $urandom;
        it.saved_present  = $urandom_range(0, 99) < 85;
        it.cond_pass      = $urandom_range(0, 99) < 80;
        if ($urandom_range(0, 99) < 35)
            it.current_status[4:0] = USER_MODE_BITS;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            if (it.mode == MODE_MRS) begin
                it.instruction[19:16] = 4'hf;
                it.instruction[11:0]  = 12'h000;
            end else begin
                legal = ~UNALLOC_BY_LEVEL[lvl];
                if ($urandom_range(0, 1) == 0)
                    legal &= ~STATE_BY_LEVEL[lvl];
                if (it.instruction[25]) begin
                    // keep only immediate bits that rotate into legal positions
                    twice = {legal, legal} << {it.instruction[11:8], 1'b0};
                    it.instruction[7:0] &= twice[39:32];
                end else begin
                    it.instruction[7:4] = 4'h0;
                    it.source_value &= legal;
                end
            end
        end
        return it;
    endfunction

    task automatic queue_item(input t_item it);
        t_backlog_entry e;
        e.is_cfg = 1'b0;
        e.level  = 3'd0;
        e.it     = it;
        instr_backlog.push_back(e);
    endtask

    task automatic queue_level(input logic [2:0] lvl);
        t_backlog_entry e;
        e.is_cfg = 1'b1;
        e.level  = lvl;
        e.it     = '0;
        instr_backlog.push_back(e);
    endtask

    task automatic compare_field(input string label, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", label, want_v, got_v);
            mismatches++;
        end
    endtask

    // Driver: predict each accepted item, then advance to the next backlog entry.
    // Config writes wait until every issued item has returned its result.
    always @(posedge i_clk) begin : drive_items
        t_backlog_entry head;
        logic           taken, nxt_start, nxt_we;
        int unsigned    roll;
        taken = start && !busy;
        nxt_start = start;
        nxt_we = 1'b0;
        if (i_cfg_we)
            arch_shadow = i_cfg_wdata;
        if (i_rst_n) begin
            if (taken) begin
                psr_expected.push_back(transfer_outcome(on_port, arch_shadow));
                n_sent++;
            end
            // hold the item while it is refused, otherwise pick the next move
            if (!start || taken) begin
                nxt_start = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (instr_backlog.size() != 0) begin
                    head = instr_backlog[0];
                    if (head.is_cfg) begin
                        if (!taken && !i_cfg_we && n_sent == n_results) begin
                            nxt_we = 1'b1;
                            i_cfg_wdata <= head.level;
                            void'(instr_backlog.pop_front());
                        end
                    end else begin
                        void'(instr_backlog.pop_front());
                        on_port = head.it;
                        i_mode           <= head.it.mode;
                        i_instruction    <= head.it.instruction;
                        i_source_value   <= head.it.source_value;
                        i_current_status <= head.it.current_status;
                        i_saved_status   <= head.it.saved_status;
                        i_saved_present  <= head.it.saved_present;
                        i_cond_pass      <= head.it.cond_pass;
                        nxt_start = 1'b1;
                        // mostly short gaps, a few long ones, and calm stretches
                        if (calm_left > 0) begin
                            calm_left--;
                            gap_left = 0;
                        end else begin
                            roll = $urandom_range(0, 99);
                            if (roll < 4)
                                calm_left = $urandom_range(20, 80);
                            if (roll < 55)
                                gap_left = 0;
                            else if (roll < 88)
                                gap_left = $urandom_range(1, 3);
                            else if (roll < 97)
                                gap_left = $urandom_range(4, 12);
                            else
                                gap_left = $urandom_range(20, 60);
                        end
                    end
                end
            end
        end
        start <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // Monitor: take every strobed result and match it to the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_strobe) begin
            n_results <= n_results + 1;
            if (psr_expected.size() == 0) begin
                $error("result with no item pending: fault %0h", o_fault);
                mismatches++;
            end else begin
                want = psr_expected.pop_front();
                compare_field("dest_reg",   32'(want.dest_reg),   32'(o_dest_reg));
                compare_field("reg_write",  32'(want.reg_write),  32'(o_reg_write));
                compare_field("reg_result", want.reg_result,      o_reg_result);
                compare_field("cpsr_write", 32'(want.cpsr_write), 32'(o_cpsr_write));
                compare_field("new_cpsr",   want.new_cpsr,        o_new_cpsr);
                compare_field("spsr_write", 32'(want.spsr_write), 32'(o_spsr_write));
                compare_field("new_spsr",   want.new_spsr,        o_new_spsr);
                compare_field("fault",      32'(want.fault),      32'(o_fault));
            end
        end
    end

    // Watchdog: drop the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : run_test
        logic [2:0] phase_levels [8];
        int         p, n;
        phase_levels = '{3'd0, 3'd7, 3'd2, 3'd1, 3'd5, 3'd3, 3'd6, 3'd4};

        // Directed items at the reset level.
        // MRS: CPSR, SPSR present, SPSR absent, bad field bits, bad low bits, cond fail
        queue_item('{MODE_MRS, 32'he10ff000, 32'h0, 32'hf00000d3, 32'h0, 1'b1, 1'b1});
        queue_item('{MODE_MRS, 32'he14f3000, 32'h0, 32'h000000d3, 32'ha5a5a5a5, 1'b1, 1'b1});
        queue_item('{MODE_MRS, 32'he14f3000, 32'h0, 32'h000000d3, 32'ha5a5a5a5, 1'b0, 1'b1});
        queue_item('{MODE_MRS, 32'he10e1000, 32'h0, 32'h000000d3, 32'h0, 1'b1, 1'b1});
        queue_item('{MODE_MRS, 32'he10f1001, 32'h0, 32'h000000d3, 32'h0, 1'b1, 1'b1});
        queue_item('{MODE_MRS, 32'he10f2000, 32'h0, 32'h600000d3, 32'h0, 1'b1, 1'b0});
        // MSR immediate: state bit while privileged, same from user mode,
        // flags via rotation, largest rotation
        queue_item('{MODE_MSR, 32'he32ff0ff, 32'h0, 32'h000000d3, 32'h0, 1'b1, 1'b1});
        queue_item('{MODE_MSR, 32'he32ff0ff, 32'h0, 32'h00000010, 32'h0, 1'b1, 1'b1});
        queue_item('{MODE_MSR, 32'he328f4f0, 32'h0, 32'h000000d3, 32'h0, 1'b1, 1'b1});
        queue_item('{MODE_MSR, 32'he321ff01, 32'h0, 32'h000000d3, 32'h0, 1'b1, 1'b1});
        // MSR register: bad bits 7:4, unallocated operand, both (encoding wins)
        queue_item('{MODE_MSR, 32'he129f0f1, 32'h0, 32'h000000d3, 32'h0, 1'b1, 1'b1});
        queue_item('{MODE_MSR, 32'he129f001, 32'h00100000, 32'h000000d3, 32'h0, 1'b1, 1'b1});
        queue_item('{MODE_MSR, 32'he129f011, 32'h00100000, 32'h000000d3, 32'h0, 1'b1, 1'b1});
        // MSR to SPSR: absent, absent with unallocated bits, full write
        queue_item('{MODE_MSR, 32'he169f001, 32'hf0000000, 32'h000000d3, 32'h0, 1'b0, 1'b1});
        queue_item('{MODE_MSR, 32'he169f001, 32'h02000000, 32'h000000d3, 32'h0, 1'b0, 1'b1});
        queue_item('{MODE_MSR, 32'he16ff002, 32'hf90f03ff, 32'h000000d3, 32'h12345678,
                     1'b1, 1'b1});
        // empty field mask, cond fail, all zeros, all ones, MRS with all free bits set
        queue_item('{MODE_MSR, 32'he120f003, 32'hf0000000, 32'h800000d3, 32'h0, 1'b1, 1'b1});
        queue_item('{MODE_MSR, 32'he128f000, 32'h50000000, 32'h000000d3, 32'h0, 1'b1, 1'b0});
        queue_item('{MODE_MRS, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0});
        queue_item('{MODE_MSR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     1'b1, 1'b1});
        queue_item('{MODE_MRS, 32'hfffff000, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     1'b1, 1'b1});

        // Random phases, one per arch level setting, extremes included.
        for (p = 0; p < 8; p++) begin
            queue_level(phase_levels[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_item(random_transfer(phase_levels[p]));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the backlog to drain and every result to come back.
        @(posedge i_clk);
        while (instr_backlog.size() != 0 || start || i_cfg_we || n_sent != n_results)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && psr_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== arm_psr_transfer_unit_top.f =====
+incdir+hdl
hdl/apsrtu_pkg.sv
hdl/apsrtu_exec.sv
hdl/arm_psr_transfer_unit_top.sv
sim/tb.sv
